// ===== src/ssr_pkg.sv =====
package ssr_pkg;

  localparam int BURST_MAX = 8;
  localparam int COUNT_W = 4;
  localparam int REG_W = 64;
  localparam int INDEX_W = 2;

  localparam logic [INDEX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0]   pattern_bytes;
    logic [COUNT_W-1:0] plen;
    logic [REG_W-1:0]   replacement_bytes;
    logic [COUNT_W-1:0] rlen;
    logic               clear;
  } cfg_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
    logic                      line_end;
  } burst_t;

endpackage

// ===== src/ssr_window.sv =====
module ssr_window
  import ssr_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       line_end,
  input  cfg_t       cfg,
  output burst_t     burst
);

  logic [7:0]         win [Depth];
  logic [7:0]         win_next [Depth];
  logic [COUNT_W-1:0] wc;
  logic [COUNT_W-1:0] wc_next;

  logic [7:0]         cur [BURST_MAX];
  logic [7:0]         nw [BURST_MAX];
  logic [7:0]         sw [BURST_MAX];
  logic [7:0]         keep [BURST_MAX];
  logic [COUNT_W-1:0] wc_eff;
  logic [COUNT_W-1:0] n;
  logic               full;
  logic               hit;
  logic               pass;

  genvar g;
  generate
    for (g = 0; g < BURST_MAX; g++) begin : g_cur
      if (g < Depth) begin : g_held
        assign cur[g] = win[g];
        assign win_next[g] = keep[g];
      end else begin : g_none
        assign cur[g] = 8'd0;
      end
    end
  endgenerate

  always_comb begin
    pass = (cfg.plen == '0);
    wc_eff = (wc >= cfg.plen && !pass) ? COUNT_W'(cfg.plen - 4'd1) : wc;
    n = COUNT_W'(wc_eff + 4'd1);
    full = (n == cfg.plen);
    for (int i = 0; i < BURST_MAX; i++) begin
      nw[i] = (COUNT_W'(i) == wc_eff) ? in_byte : cur[i];
    end
    for (int i = 0; i < BURST_MAX; i++) begin
      sw[i] = (i < BURST_MAX - 1) ? nw[(i + 1) % BURST_MAX] : 8'd0;
    end
    hit = 1'b1;
    for (int i = 0; i < BURST_MAX; i++) begin
      if (COUNT_W'(i) < cfg.plen && nw[i] != cfg.pattern_bytes[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    burst.line_end = line_end;
    for (int i = 0; i < BURST_MAX; i++) begin
      if (pass) begin
        burst.bytes[i] = (i == 0) ? in_byte : 8'd0;
      end else if (full && hit) begin
        burst.bytes[i] = cfg.replacement_bytes[8*i +: 8];
      end else begin
        burst.bytes[i] = nw[i];
      end
    end
    if (pass) begin
      burst.count = 4'd1;
    end else if (full && hit) begin
      burst.count = cfg.rlen;
    end else if (line_end) begin
      burst.count = n;
    end else if (full) begin
      burst.count = 4'd1;
    end else begin
      burst.count = '0;
    end

    if (pass || line_end || (full && hit)) begin
      wc_next = '0;
    end else if (full) begin
      wc_next = COUNT_W'(cfg.plen - 4'd1);
    end else begin
      wc_next = n;
    end
    for (int i = 0; i < BURST_MAX; i++) begin
      keep[i] = (full && !pass) ? sw[i] : nw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc <= '0;
    end else if (cfg.clear) begin
      wc <= '0;
    end else if (fire) begin
      wc <= wc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win <= win_next;
    end
  end

  a_wc_below_plen: assert property (@(posedge clk) disable iff (rst)
    (wc < cfg.plen) || (wc == '0))
    else $error("window holds a full pattern between transactions");

  a_flush_on_line_end: assert property (@(posedge clk) disable iff (rst)
    fire && line_end |=> (wc == '0))
    else $error("window not flushed at end of line");

endmodule

// ===== src/ssr_burst.sv =====
module ssr_burst
  import ssr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  burst_t     burst_new,
  output logic       can_load,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tuser,
  output logic       m_tlast
);

  logic [BURST_MAX-1:0][7:0] bytes;
  logic [COUNT_W-1:0]        count;
  logic                      line_end;

  assign m_tvalid = (count != '0);
  assign can_load = (count == '0) || (count == 4'd1 && m_tready);
  assign m_tdata  = bytes[0];
  assign m_tuser  = (count == 4'd1);
  assign m_tlast  = (count == 4'd1) && line_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= burst_new.count;
    end else if (m_tvalid && m_tready) begin
      count <= COUNT_W'(count - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bytes    <= burst_new.bytes;
      line_end <= burst_new.line_end;
    end else if (m_tvalid && m_tready) begin
      bytes <= {8'd0, bytes[BURST_MAX-1:1]};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(BURST_MAX))
    else $error("burst count out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tlast |-> m_tuser)
    else $error("line end on a result that does not end its run");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !fire && count > 4'd1 |=> count == $past(count) - 4'd1)
    else $error("burst count did not step down after a transaction");

endmodule

// ===== src/stream_substring_replacer.sv =====
// Streaming find and replace over lines of text, one byte per transaction.
// The slave stream carries one byte of a line in s_tdata with s_tlast on the
// final byte of the line. The master stream carries the rewritten bytes;
// m_tuser marks the last result of one input transaction and m_tlast marks
// the result that ends the rewritten line.
// The pattern, its length, the replacement and its length are written through
// the cfg_we / cfg_index / cfg_data port while no transaction is in flight.
// Writing the pattern length discards any bytes held in the match window.
// An accepted byte is held in the input register and is then turned into a
// burst of 0 to 8 result bytes in the output register, from which its first
// result can be taken. The output register sends one result per cycle while
// m_tready is high. A byte that yields at most one result lets a new byte
// enter every cycle while m_tready is high; a byte that yields more results
// holds the input until its last result is being taken, since the output
// register is the only place a burst waits.
// When the receiver stalls, the burst waits in the output register and the
// input register fills, after which s_tready drops.
// Reset empties the window and both registers and clears all configuration.
module stream_substring_replacer
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // in_byte
  input  logic               s_tlast,   // line_end
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // out_byte
  output logic               m_tuser,   // run_last
  output logic               m_tlast,   // line_done
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  localparam int PatLimit = (MAX_PATTERN < BURST_MAX) ? MAX_PATTERN : BURST_MAX;
  localparam int RepLimit = (MAX_REPLACEMENT < BURST_MAX) ? MAX_REPLACEMENT : BURST_MAX;

  logic [REG_W-1:0]   pattern_bytes;
  logic [COUNT_W-1:0] pattern_length;
  logic [REG_W-1:0]   replacement_bytes;
  logic [COUNT_W-1:0] replacement_length;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_load;
  logic       fire;
  cfg_t       cfg;
  burst_t     burst_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[COUNT_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern_bytes     = pattern_bytes;
    cfg.plen              = (pattern_length > COUNT_W'(PatLimit)) ?
                            COUNT_W'(PatLimit) : pattern_length;
    cfg.replacement_bytes = replacement_bytes;
    cfg.rlen              = (replacement_length > COUNT_W'(RepLimit)) ?
                            COUNT_W'(RepLimit) : replacement_length;
    cfg.clear             = cfg_we && (cfg_index == REG_PATTERN_LENGTH);
  end

  assign s_tready = !in_valid || can_load;
  assign fire     = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ssr_window #(
    .Depth(PatLimit)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .in_byte  (in_byte),
    .line_end (in_last),
    .cfg      (cfg),
    .burst    (burst_new)
  );

  ssr_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .burst_new (burst_new),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
